@@ src/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;
  localparam int OPERAND_WIDTH = 32;
  localparam int WW = 64;
  localparam int QDEPTH = 2;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Classified job handed from front to back
  typedef struct packed {
    logic          zero_zero;
    logic          den_zero;
    logic          num_zero;
    logic          neg;
    logic [WW-1:0] un;
    logic [WW-1:0] ud;
  } job_t;
endpackage

@@ src/rau_front.sv @@
// Front end: operand saturation, raw products, classification.
module rau_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic signed [31:0]  in_a_num,
  input  logic signed [31:0]  in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic signed [31:0]  in_b_den,
  output logic                job_valid,
  input  logic                job_ready,
  output rau_pkg::job_t       job
);
  import rau_pkg::*;

  localparam int OW = OPERAND_WIDTH;

  logic              st_r, st_nxt;
  logic [1:0]        cmd_r;
  logic signed [WW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [WW-1:0] s_an, s_ad, s_bn, s_bd;
  logic              jv_r, jv_nxt;
  job_t              job_r, job_nxt;
  logic signed [WW-1:0] n, d;

  function automatic logic signed [WW-1:0] take(input logic [31:0] raw);
    logic signed [OW-1:0] v;
    logic signed [OW-1:0] lim;
    v   = raw[OW-1:0];
    lim = {1'b1, {(OW-2){1'b0}}, 1'b1};
    if (v == {1'b1, {(OW-1){1'b0}}}) v = lim;
    return WW'(v);
  endfunction

  assign s_an = take(in_a_num);
  assign s_ad = take(in_a_den);
  assign s_bn = take(in_b_num);
  assign s_bd = take(in_b_den);

  // Accept only when product stage and output slot are free
  assign in_ready = !st_r && !jv_r;

  // Register the four products (one 32x32 each)
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      p0_r  <= s_an * s_bd;
      p1_r  <= s_ad * s_bn;
      p2_r  <= s_an * s_bn;
      p3_r  <= s_ad * s_bd;
    end
  end

  always_comb begin
    unique case (cmd_r)
      CMD_ADD: begin n = p0_r + p1_r; d = p3_r; end
      CMD_SUB: begin n = p0_r - p1_r; d = p3_r; end
      CMD_MUL: begin n = p2_r;        d = p3_r; end
      default: begin n = p0_r;        d = p1_r; end
    endcase
    job_nxt.zero_zero = (n == 0) && (d == 0);
    job_nxt.den_zero  = (d == 0);
    job_nxt.num_zero  = (n == 0);
    job_nxt.neg       = n[WW-1] ^ d[WW-1];
    job_nxt.un        = n[WW-1] ? WW'(-n) : WW'(n);
    job_nxt.ud        = d[WW-1] ? WW'(-d) : WW'(d);
  end

  always_comb begin
    st_nxt = st_r;
    jv_nxt = jv_r;
    if (jv_r && job_ready) jv_nxt = 1'b0;
    if (st_r) begin
      st_nxt = 1'b0;
      jv_nxt = 1'b1;
    end
    if (in_valid && in_ready) st_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= 1'b0;
      jv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      jv_r <= jv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r) job_r <= job_nxt;
  end

  assign job_valid = jv_r;
  assign job       = job_r;
endmodule

@@ src/rau_queue.sv @@
// Short FIFO of classified jobs between front and back.
module rau_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rau_pkg::job_t  wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output rau_pkg::job_t  rd_data
);
  import rau_pkg::*;

  job_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

@@ src/rau_back.sv @@
// Back end: binary GCD, two restoring divisions, sign fixup, output register.
module rau_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  rau_pkg::job_t       job,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  out_res_num,
  output logic [62:0]         out_res_den,
  output logic                out_undefined_flag
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALGN = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_DIVD = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    st_r;
  logic [WW-1:0] un_r, ud_r, x_r, y_r, q_r, rem_r, dvd_r;
  logic [6:0]    k_r, cnt_r;
  logic          neg_r;
  logic [WW-1:0] g;
  logic [WW:0]   trial;
  logic [WW-1:0] rsh;
  logic          ov_r;

  assign job_ready = (st_r == S_IDLE) && !ov_r;
  assign g = x_r << k_r[5:0];
  assign rsh = {rem_r[WW-2:0], dvd_r[WW-1]};
  assign trial = {rem_r[WW-1], rsh} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (job_valid && !ov_r) begin
            neg_r <= job.neg;
            un_r  <= job.un;
            ud_r  <= job.ud;
            x_r   <= job.un;
            y_r   <= job.ud;
            k_r   <= 7'd0;
            // Settle special cases at once
            if (job.zero_zero) begin
              out_res_num <= '0; out_res_den <= '0; out_undefined_flag <= 1'b1;
              st_r <= S_DONE;
            end else if (job.den_zero) begin
              out_res_num <= 64'sd1; out_res_den <= '0; out_undefined_flag <= 1'b0;
              st_r <= S_DONE;
            end else if (job.num_zero) begin
              out_res_num <= '0; out_res_den <= 63'd1; out_undefined_flag <= 1'b0;
              st_r <= S_DONE;
            end else begin
              st_r <= S_ALGN;
            end
          end
        end
        // Strip common factors of two, then make x odd
        S_ALGN: begin
          if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1; y_r <= y_r >> 1; k_r <= k_r + 7'd1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else begin
            st_r <= S_GCD;
          end
        end
        // x odd; reduce y to zero
        S_GCD: begin
          if (y_r == 0) begin
            st_r <= S_DIVN; dvd_r <= un_r; rem_r <= '0; q_r <= '0;
            cnt_r <= 7'd0;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (y_r >= x_r) begin
            y_r <= (y_r - x_r) >> 1;
          end else begin
            y_r <= (x_r - y_r) >> 1; x_r <= y_r;
          end
        end
        S_DIVN, S_DIVD: begin
          dvd_r <= dvd_r << 1;
          if (!trial[WW]) begin
            rem_r <= trial[WW-1:0]; q_r <= {q_r[WW-2:0], 1'b1};
          end else begin
            rem_r <= rsh; q_r <= {q_r[WW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(WW-1)) begin
            if (st_r == S_DIVN) begin
              un_r <= {q_r[WW-2:0], !trial[WW]};
              dvd_r <= ud_r; rem_r <= '0; q_r <= '0; cnt_r <= 7'd0;
              st_r <= S_DIVD;
            end else begin
              out_res_num <= neg_r ? -$signed(un_r) : $signed(un_r);
              out_res_den <= {q_r[WW-3:0], !trial[WW]};
              out_undefined_flag <= 1'b0;
              st_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
endmodule

@@ src/rational_arith_unit.sv @@
// Top level of the rational arithmetic unit.
// The back end takes a new job only when idle and its output register is empty;
// it runs the binary GCD and then the two 64-step divisions one after another
// for each job.
// The front end forms products, and a queue holds up to two jobs while the back end works.
// Reset: synchronous active-low rst_n clears all handshake and sequencer state.
module rational_arith_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_res_num,
  output logic [62:0]        out_res_den,
  output logic               out_undefined_flag
);
  import rau_pkg::*;

  job_t fj, bj;
  logic fv, fr, bv, br;

  rau_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .job_valid(fv), .job_ready(fr), .job(fj)
  );

  rau_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(bv), .rd_ready(br), .rd_data(bj)
  );

  rau_back u_back (
    .clk, .rst_n, .job_valid(bv), .job_ready(br), .job(bj),
    .out_valid, .out_ready, .out_res_num, .out_res_den, .out_undefined_flag
  );
endmodule

@@ src/rau_checker.sv @@
// Port-level checks for the rational arithmetic unit, bound to the top level.
module rau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] out_res_num,
  input logic [62:0]        out_res_den,
  input logic               out_undefined_flag
);
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_undefined_flag |-> out_res_num == 0 && out_res_den == 0)
    else $error("undefined result not 0/0");
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_undefined_flag && out_res_den == 0 |-> out_res_num == 1)
    else $error("zero denominator without 1/0");
  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res_num == 0 && !out_undefined_flag |-> out_res_den == 1)
    else $error("zero numerator not over 1");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num))
    else $error("result dropped while stalled");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
